/* rtl/int8_conv_mac_requantize_unit_assert.svh */
// Assertion macros shared by the requantizing MAC unit.
// Depends on nothing; included by the files that carry checks.
`ifndef INT8_CONV_MAC_REQUANTIZE_UNIT_ASSERT_SVH
`define INT8_CONV_MAC_REQUANTIZE_UNIT_ASSERT_SVH

// Condition must hold at every edge out of reset
`define ICMR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("icmr check failed");

// Same-cycle implication
`define ICMR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("icmr check failed");

// Next-cycle implication
`define ICMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icmr check failed");

`endif

/* rtl/icmr_pkg.sv */
// Package for the requantizing MAC unit: widths, register indexes,
// reset values and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package icmr_pkg;

	localparam int ACT_W      = 8;
	localparam int OFS_W      = 9;
	localparam int OPD_W      = 10;
	localparam int TERM_W     = 2 * OPD_W;
	localparam int ACC_W      = 32;
	localparam int PROD_W     = 2 * ACC_W;
	localparam int MULT_W     = 31;
	localparam int SHIFT_W    = 6;
	localparam int RES_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int DEF_SUM_DEPTH = 4;
	localparam int DEF_RES_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_ZERO_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_ZERO_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULTIPLIER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW          = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH         = 3'd6;

	// reset values
	localparam logic [MULT_W-1:0] RST_SCALE_MULT = 31'h4000_0000;
	localparam logic [RES_W-1:0]  RST_CLAMP_LOW  = 8'h80;
	localparam logic [RES_W-1:0]  RST_CLAMP_HIGH = 8'h7f;

	// rounding constant of the Q0.31 scaling, 2^30
	localparam logic [PROD_W-1:0] SCALE_ROUND = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic signed [OFS_W-1:0]   in_ofs;
		logic signed [OFS_W-1:0]   w_ofs;
		logic signed [RES_W-1:0]   res_ofs;
		logic        [MULT_W-1:0]  mult;
		logic signed [SHIFT_W-1:0] shift;
		logic signed [RES_W-1:0]   clamp_lo;
		logic signed [RES_W-1:0]   clamp_hi;
	} cfg_t;

endpackage

/* rtl/icmr_fifo.sv */
// Small register-based FIFO used for the sum queue and the result queue.
// Depends on int8_conv_mac_requantize_unit_assert.svh.
`timescale 1ns / 1ps
`include "int8_conv_mac_requantize_unit_assert.svh"

module icmr_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         rd,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (rd) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign count = cnt_q;

	`ICMR_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, wr, !full)
	`ICMR_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, rd, !empty)
	`ICMR_ASSERT_NEXT(a_count_rises, clk, arst_n, wr && !rd, cnt_q == $past(cnt_q) + 1'b1)

endmodule

/* rtl/icmr_mac_front.sv */
// Front end: forms each convolution term and runs the 32-bit accumulator.
// A last term hands the finished sum to the sum queue. Uses icmr_pkg.
`timescale 1ns / 1ps

module icmr_mac_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  icmr_pkg::cfg_t                       cfg,
	input  logic                                 take,
	input  logic signed [icmr_pkg::ACT_W-1:0]    activation,
	input  logic                                 padding,
	input  logic signed [icmr_pkg::ACT_W-1:0]    weight,
	input  logic signed [icmr_pkg::ACC_W-1:0]    bias,
	input  logic                                 first,
	input  logic                                 last,
	output logic                                 sum_wr,
	output logic [icmr_pkg::ACC_W-1:0]           sum_data,
	output logic                                 pend
);

	import icmr_pkg::*;

	logic signed [OPD_W-1:0]  opa, opb;
	logic signed [TERM_W-1:0] term;

	logic                     valid_s1;
	logic signed [TERM_W-1:0] term_s1;
	logic [ACC_W-1:0]         bias_s1;
	logic                     first_s1, last_s1;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_base, acc_next;

	// operand offsets and term product
	always_comb begin
		if (padding) begin
			opa = {cfg.in_ofs[OFS_W-1], cfg.in_ofs};
		end else begin
			opa = {{2{activation[ACT_W-1]}}, activation} + {cfg.in_ofs[OFS_W-1], cfg.in_ofs};
		end
		opb  = {{2{weight[ACT_W-1]}}, weight} + {cfg.w_ofs[OFS_W-1], cfg.w_ofs};
		term = opa * opb;
	end

	// term register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			term_s1  <= term;
			bias_s1  <= bias;
			first_s1 <= first;
			last_s1  <= last;
		end
	end

	// accumulate, restarting from bias on a first term
	always_comb begin
		acc_base = first_s1 ? bias_s1 : acc_q;
		acc_next = acc_base + {{(ACC_W-TERM_W){term_s1[TERM_W-1]}}, term_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_next;
		end
	end

	assign sum_wr   = valid_s1 && last_s1;
	assign sum_data = acc_next;
	assign pend     = valid_s1 && last_s1;

endmodule

/* rtl/icmr_requant_back.sv */
// Back end: Q0.31 scaling, rounding/left shift, output offset and clamp.
// Three register stages; issues only with room reserved in the result queue.
// Uses icmr_pkg.
`timescale 1ns / 1ps

module icmr_requant_back #(
	parameter int RES_DEPTH = icmr_pkg::DEF_RES_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  icmr_pkg::cfg_t                       cfg,
	input  logic                                 sum_empty,
	input  logic [icmr_pkg::ACC_W-1:0]           sum_data,
	output logic                                 sum_rd,
	input  logic [$clog2(RES_DEPTH+1)-1:0]       res_count,
	output logic                                 res_wr,
	output logic [icmr_pkg::RES_W-1:0]           res_data,
	output logic [1:0]                           inflight
);

	import icmr_pkg::*;

	localparam int FILL_W = $clog2(RES_DEPTH + 1) + 2;

	logic [FILL_W-1:0] fill;
	logic              issue;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  scaled_s2;
	logic signed [ACC_W-1:0]  shifted_s3;

	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        rnd;
	logic [4:0]               ramt;
	logic [SHIFT_W-1:0]       lamt;
	logic signed [ACC_W:0]    rtmp, rshift;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W-1:0]  offs, lo32, hi32, v_lo, v_hi;

	// credit: result queue plus stages in flight must not exceed depth
	assign inflight = 2'(valid_s1) + 2'(valid_s2) + 2'(valid_s3);
	assign fill     = FILL_W'(res_count) + FILL_W'(inflight);
	assign issue    = !sum_empty && (fill < FILL_W'(RES_DEPTH));
	assign sum_rd   = issue;

	// stage 1: accumulator times Q0.31 multiplier
	assign prod = $signed(sum_data) * $signed({1'b0, cfg.mult});

	// stage 2: round at 2^30, drop 31 fraction bits
	assign rnd = prod_s1 + SCALE_ROUND;

	// stage 3: rounding right shift or wrapping left shift
	always_comb begin
		ramt   = cfg.shift[4:0];
		lamt   = -cfg.shift;
		rtmp   = {scaled_s2[ACC_W-1], scaled_s2} + ((ACC_W+1)'(1) << (ramt - 5'd1));
		rshift = rtmp >>> ramt;
		if (!cfg.shift[SHIFT_W-1] && (cfg.shift != '0)) begin
			shifted = rshift[ACC_W-1:0];
		end else if (cfg.shift[SHIFT_W-1]) begin
			shifted = lamt[SHIFT_W-1] ? '0 : (scaled_s2 << lamt[4:0]);
		end else begin
			shifted = scaled_s2;
		end
	end

	// output offset with wrap, then clamp low before high
	always_comb begin
		offs = shifted_s3 + {{(ACC_W-RES_W){cfg.res_ofs[RES_W-1]}}, cfg.res_ofs};
		lo32 = {{(ACC_W-RES_W){cfg.clamp_lo[RES_W-1]}}, cfg.clamp_lo};
		hi32 = {{(ACC_W-RES_W){cfg.clamp_hi[RES_W-1]}}, cfg.clamp_hi};
		v_lo = (offs < lo32) ? lo32 : offs;
		v_hi = (v_lo > hi32) ? hi32 : v_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= prod;
		end
		if (valid_s1) begin
			scaled_s2 <= rnd[62:31];
		end
		if (valid_s2) begin
			shifted_s3 <= shifted;
		end
	end

	assign res_wr   = valid_s3;
	assign res_data = v_hi[RES_W-1:0];

endmodule

/* rtl/int8_conv_mac_requantize_unit.sv */
// Top level of the int8 convolution MAC with requantization.
// Uses icmr_pkg, icmr_mac_front, icmr_fifo, icmr_requant_back.
//
// Usage:
//  - Input queue: one convolution term per beat, taken when push is high and
//    full is low. first restarts the sum from bias; last closes the output.
//  - Result queue: one int8 result per last term; result is valid while empty
//    is low and leaves on pop.
//  - Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
//    write only while no term is in flight. Unknown indexes are ignored.
//  - Throughput: one term per cycle while full is low; the accumulator add is not pipelined.
//  - Path: a last term's result reaches the result ports through the term
//    register, the sum queue write, three requantize stages and the result
//    queue write; it waits in the sum queue while no result slot is free.
//  - full rises when the sum queue has no room for a finished sum; the
//    requantizer issues only with a result slot reserved, so a stalled pop
//    backs up into the sum queue and then into full.
//  - Reset (arst_n low) empties both queues, clears the accumulator and loads
//    the default register values.
`timescale 1ns / 1ps
`include "int8_conv_mac_requantize_unit_assert.svh"

module int8_conv_mac_requantize_unit #(
	parameter int SUM_DEPTH = icmr_pkg::DEF_SUM_DEPTH,
	parameter int RES_DEPTH = icmr_pkg::DEF_RES_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [icmr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [icmr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [icmr_pkg::ACT_W-1:0]     activation,
	input  logic                                  padding,
	input  logic signed [icmr_pkg::ACT_W-1:0]     weight,
	input  logic signed [icmr_pkg::ACC_W-1:0]     bias,
	input  logic                                  first,
	input  logic                                  last,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [icmr_pkg::RES_W-1:0]     result
);

	import icmr_pkg::*;

	localparam int SUM_CNT_W = $clog2(SUM_DEPTH + 1);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	cfg_t cfg_q;

	logic                 take;
	logic                 sum_wr, sum_rd, sum_empty, sum_full;
	logic [ACC_W-1:0]     sum_wdata, sum_rdata;
	logic [SUM_CNT_W-1:0] sum_count;
	logic [SUM_CNT_W:0]   sum_fill;
	logic                 pend;

	logic                 res_wr, res_full;
	logic [RES_W-1:0]     res_wdata, res_rdata;
	logic [RES_CNT_W-1:0] res_count;
	logic [1:0]           inflight;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_ofs   <= '0;
			cfg_q.w_ofs    <= '0;
			cfg_q.res_ofs  <= '0;
			cfg_q.mult     <= RST_SCALE_MULT;
			cfg_q.shift    <= '0;
			cfg_q.clamp_lo <= RST_CLAMP_LOW;
			cfg_q.clamp_hi <= RST_CLAMP_HIGH;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INPUT_ZERO_OFFSET: begin
					cfg_q.in_ofs <= cfg_data[OFS_W-1:0];
				end
				REG_WEIGHT_ZERO_OFFSET: begin
					cfg_q.w_ofs <= cfg_data[OFS_W-1:0];
				end
				REG_RESULT_ZERO_OFFSET: begin
					cfg_q.res_ofs <= cfg_data[RES_W-1:0];
				end
				REG_SCALE_MULTIPLIER: begin
					cfg_q.mult <= cfg_data[MULT_W-1:0];
				end
				REG_SCALE_SHIFT: begin
					cfg_q.shift <= cfg_data[SHIFT_W-1:0];
				end
				REG_CLAMP_LOW: begin
					cfg_q.clamp_lo <= cfg_data[RES_W-1:0];
				end
				REG_CLAMP_HIGH: begin
					cfg_q.clamp_hi <= cfg_data[RES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input side: a sum already on its way to the queue counts as taken
	assign sum_fill = (SUM_CNT_W+1)'(sum_count) + (SUM_CNT_W+1)'(pend);
	assign full     = (sum_fill >= (SUM_CNT_W+1)'(SUM_DEPTH));
	assign take     = push && !full;

	icmr_mac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.take       (take),
		.activation (activation),
		.padding    (padding),
		.weight     (weight),
		.bias       (bias),
		.first      (first),
		.last       (last),
		.sum_wr     (sum_wr),
		.sum_data   (sum_wdata),
		.pend       (pend)
	);

	icmr_fifo #(
		.WIDTH (ACC_W),
		.DEPTH (SUM_DEPTH)
	) u_sum_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (sum_wr),
		.wdata  (sum_wdata),
		.rd     (sum_rd),
		.rdata  (sum_rdata),
		.empty  (sum_empty),
		.full   (sum_full),
		.count  (sum_count)
	);

	icmr_requant_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sum_empty (sum_empty),
		.sum_data  (sum_rdata),
		.sum_rd    (sum_rd),
		.res_count (res_count),
		.res_wr    (res_wr),
		.res_data  (res_wdata),
		.inflight  (inflight)
	);

	icmr_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_wdata),
		.rd     (pop && !empty),
		.rdata  (res_rdata),
		.empty  (empty),
		.full   (res_full),
		.count  (res_count)
	);

	assign result = res_rdata;

	`ICMR_ASSERT_IMPLIES(a_sum_room, clk, arst_n, sum_wr, !sum_full)
	`ICMR_ASSERT_ALWAYS(a_res_credit, clk, arst_n, ({2'b00, res_count} + inflight) <= RES_DEPTH)
	`ICMR_ASSERT_NEXT(a_last_pends, clk, arst_n, take && last, pend && sum_wr)
	`ICMR_ASSERT_ALWAYS(a_res_no_drop, clk, arst_n, !(res_wr && res_full && !(pop && !empty)))

endmodule
